### src/jbp_pkg.sv
// Shared types and constants for the JPEG bit packer with byte stuffing.
package jbp_pkg;

    localparam int unsigned CodeW   = 32;
    localparam int unsigned LenW    = 6;
    localparam int unsigned PartW   = 7;
    localparam int unsigned AccW    = PartW + CodeW;
    localparam int unsigned TotalW  = 6;

    localparam logic [LenW-1:0] MaxLen  = 6'd32;
    localparam logic [7:0]      ByteFf  = 8'hff;
    localparam logic [7:0]      ByteZero = 8'h00;

    typedef enum logic {
        CMD_APPEND = 1'b0,
        CMD_FLUSH  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             cmd;
        logic [CodeW-1:0] code_bits;
        logic [LenW-1:0]  code_length;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_req;

    // Controller to datapath.
    typedef struct packed {
        logic load;        // take the accepted request into the shifter
        logic emit_data;   // move the top byte to the output register
        logic emit_stuff;  // put a stuffed zero byte in the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic has_byte;    // at least eight bits pending
        logic byte_ff;     // top byte is 0xFF
    } t_dp_status;

endpackage

### src/jbp_ctrl.sv
// Controller: accepts requests, sequences byte and stuff emission, owns output valid.
module jbp_ctrl import jbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_STUFF
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_status.has_byte) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.emit_data = 1'b1;
                    n_out_valid     = 1'b1;
                    if (i_status.byte_ff) begin
                        n_state = S_STUFF;
                    end
                end
            end
            S_STUFF: begin
                if (out_free) begin
                    o_cmd.emit_stuff = 1'b1;
                    n_out_valid      = 1'b1;
                    n_state          = S_RUN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(o_cmd.emit_data || o_cmd.emit_stuff))
        else $error("output register overwritten while held");

    a_ff_then_stuff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_data && i_status.byte_ff) |=> (r_state == S_STUFF))
        else $error("0xFF byte not followed by stuff state");

    a_emit_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_data |-> i_status.has_byte)
        else $error("byte emitted with fewer than eight bits pending");

endmodule

### src/jbp_dp.sv
// Datapath: left-aligned bit shifter, pending bit count and output byte register.
module jbp_dp import jbp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_req    i_in_req,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output t_out_req   o_out_req
);

    logic [AccW-1:0]   r_sh, n_sh;
    logic [TotalW-1:0] r_total, n_total;
    t_out_req          r_out;

    logic [LenW-1:0]   len;
    logic [CodeW-1:0]  code_left;
    logic [2:0]        cnt;
    logic [7:0]        top_byte;
    logic [7:0]        padded;

    assign cnt      = r_total[2:0];
    assign top_byte = r_sh[AccW-1 -: 8];
    assign len      = (i_in_req.code_length > MaxLen) ? MaxLen : i_in_req.code_length;
    // Left-align the code; a zero length shifts everything out.
    assign code_left = i_in_req.code_bits << (MaxLen - len);
    assign padded    = {r_sh[AccW-1 -: PartW], 1'b0} | (ByteFf >> cnt);

    assign o_status.has_byte = (r_total >= TotalW'(8));
    assign o_status.byte_ff  = (top_byte == ByteFf);
    assign o_out_req         = r_out;

    always_comb begin
        n_sh    = r_sh;
        n_total = r_total;
        if (i_cmd.load) begin
            if (i_in_req.cmd == CMD_FLUSH) begin
                // Clear the shifter when nothing is pending so no pad bits linger.
                n_sh    = (cnt != 3'd0) ? {padded, {(AccW-8){1'b0}}} : '0;
                n_total = (cnt != 3'd0) ? TotalW'(8) : '0;
            end else begin
                n_sh    = {r_sh[AccW-1 -: PartW], {CodeW{1'b0}}}
                        | ({code_left, {PartW{1'b0}}} >> cnt);
                n_total = TotalW'(cnt) + TotalW'(len);
            end
        end else if (i_cmd.emit_data) begin
            n_sh    = r_sh << 8;
            n_total = r_total - TotalW'(8);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh    <= '0;
            r_total <= '0;
        end else begin
            r_sh    <= n_sh;
            r_total <= n_total;
        end
    end

    // Mark last when nothing further follows this byte.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_data) begin
            r_out.out_byte <= top_byte;
            r_out.last     <= (top_byte != ByteFf) && (r_total < TotalW'(16));
        end else if (i_cmd.emit_stuff) begin
            r_out.out_byte <= ByteZero;
            r_out.last     <= (r_total < TotalW'(8));
        end
    end

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TotalW'(AccW))
        else $error("pending bit count out of range");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_total < TotalW'(8)))
        else $error("request loaded while bytes still pending");

endmodule

### src/jpeg_bit_packer_byte_stuffing.sv
// Top level: JPEG entropy bit packer with 0xFF/0x00 byte stuffing.
//
//  channel | direction | handshake                        | payload
//  in      | input     | i_in_valid / o_in_stall          | i_in_req  (cmd, code_bits, code_length)
//  out     | output    | o_out_valid / i_out_stall        | o_out_req (out_byte, last)
//
// A request is loaded, then the controller steps the single byte shifter to emit
// each byte (stuffed zeros included) while the output is free, then returns to idle.
// Synchronous active-low reset clears the pending bits and the output valid.
// A stalled output holds the shifter; input is stalled until the request is done.
module jpeg_bit_packer_byte_stuffing import jbp_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_req  i_in_req,
    output logic     o_in_stall,
    output logic     o_out_valid,
    output t_out_req o_out_req,
    input  logic     i_out_stall
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    jbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    jbp_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_req  (i_in_req),
        .i_cmd     (dp_cmd),
        .o_status  (dp_status),
        .o_out_req (o_out_req)
    );

endmodule
